### design/fbsm_pkg.sv
// Shared types and constants for the frame buffer slot manager.
package fbsm_pkg;

   // Number of frame buffer slots and the index width needed to address them.
   localparam int SLOT_COUNT = 3;
   localparam int SLOT_SEL_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   // Operation codes carried by a request word.
   typedef enum logic [2:0] {
      OP_ACQUIRE   = 3'd0,
      OP_RELEASE   = 3'd1,
      OP_PUBLISH   = 3'd2,
      OP_PRESENT   = 3'd3,
      OP_RESET_ALL = 3'd4
   } op_type;

   // Life cycle of one slot.
   typedef enum logic [1:0] {
      ST_FREE    = 2'd0,
      ST_FILLING = 2'd1,
      ST_READY   = 2'd2,
      ST_FRONT   = 2'd3
   } slot_state_type;

   // One request word.
   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] slot_index;
      logic       queue_accepted;
      logic       count_as_drop;
   } req_word_type;

   // One response word.
   typedef struct packed {
      logic        granted;
      logic [3:0]  granted_slot;
      logic        took_effect;
      logic        shown_valid;
      logic [3:0]  shown_slot;
      logic [31:0] drop_total;
   } rsp_word_type;

endpackage

### design/frame_buffer_slot_manager_unit.sv
// Frame buffer slot manager: slot states, front slot and dropped frame count.
// Each request word passes through the request register, then the response register.
// Throughput: one word per cycle while the response side is not stalled; the slot update is
// one pass of logic between the request register and the response register, and the state
// is written as the word moves on.
// Reset (synchronous, active high): all slots free, no front slot, drop count zero.
module frame_buffer_slot_manager_unit
   import fbsm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   // Request register.
   logic         req_valid_ff;
   req_word_type req_word_ff;

   // Response register.
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;
   rsp_word_type rsp_word_in;

   // Architectural state.
   slot_state_type                  slot_states_ff [SLOT_COUNT];
   slot_state_type                  slot_states_in [SLOT_COUNT];
   logic [SLOT_SEL_W-1:0]           front_slot_ff;
   logic [SLOT_SEL_W-1:0]           front_slot_in;
   logic                            front_valid_ff;
   logic                            front_valid_in;
   logic [31:0]                     dropped_frames_ff;
   logic [31:0]                     dropped_frames_in;

   // Working signals.
   logic                  advance;
   logic                  in_range;
   logic [SLOT_SEL_W-1:0] sel;
   slot_state_type        cur_state;
   logic                  free_found;
   logic [SLOT_SEL_W-1:0] free_idx;
   logic                  any_busy;
   logic                  drop_inc;
   logic                  granted;
   logic [SLOT_SEL_W-1:0] granted_idx;
   logic                  effect;

   // The request word moves on when the response register is empty or being drained.
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Lowest free slot and whether any slot is in use.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      any_busy   = 1'b0;
      for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
         if (slot_states_ff[k] == ST_FREE) begin
            free_found = 1'b1;
            free_idx   = SLOT_SEL_W'(k);
         end else begin
            any_busy = 1'b1;
         end
      end
   end

   // Addressed slot; its state is used only when the index is in range.
   assign in_range  = req_word_ff.slot_index < 8'(SLOT_COUNT);
   assign sel       = req_word_ff.slot_index[SLOT_SEL_W-1:0];
   assign cur_state = in_range ? slot_states_ff[sel] : ST_FREE;

   // Next state and response for the word in the request register.
   always_comb begin
      slot_states_in = slot_states_ff;
      front_slot_in  = front_slot_ff;
      front_valid_in = front_valid_ff;
      drop_inc       = 1'b0;
      granted        = 1'b0;
      granted_idx    = '0;
      effect         = 1'b0;

      unique case (req_word_ff.operation)
         OP_ACQUIRE: begin
            if (free_found) begin
               slot_states_in[free_idx] = ST_FILLING;
               granted     = 1'b1;
               granted_idx = free_idx;
               effect      = 1'b1;
            end else begin
               drop_inc = 1'b1;
            end
         end
         OP_RELEASE: begin
            if (in_range) begin
               if (cur_state == ST_FILLING) begin
                  slot_states_in[sel] = ST_FREE;
                  effect = 1'b1;
               end
               drop_inc = req_word_ff.count_as_drop;
            end
         end
         OP_PUBLISH: begin
            if (in_range) begin
               if (cur_state == ST_FILLING) begin
                  effect = 1'b1;
                  if (req_word_ff.queue_accepted) begin
                     slot_states_in[sel] = ST_READY;
                  end else begin
                     slot_states_in[sel] = ST_FREE;
                     drop_inc = 1'b1;
                  end
               end else begin
                  drop_inc = 1'b1;
               end
            end
         end
         OP_PRESENT: begin
            if (in_range && (cur_state == ST_READY || cur_state == ST_FILLING)) begin
               // The old front slot goes back to the free pool.
               if (front_valid_ff && front_slot_ff != sel) begin
                  slot_states_in[front_slot_ff] = ST_FREE;
               end
               slot_states_in[sel] = ST_FRONT;
               front_slot_in  = sel;
               front_valid_in = 1'b1;
               effect = 1'b1;
            end
         end
         OP_RESET_ALL: begin
            for (int k = 0; k < SLOT_COUNT; k++) begin
               slot_states_in[k] = ST_FREE;
            end
            front_slot_in  = '0;
            front_valid_in = 1'b0;
            effect         = any_busy;
         end
         default: begin
         end
      endcase

      dropped_frames_in = drop_inc ? dropped_frames_ff + 32'd1 : dropped_frames_ff;

      rsp_word_in.granted      = granted;
      rsp_word_in.granted_slot = 4'(granted_idx);
      rsp_word_in.took_effect  = effect;
      rsp_word_in.shown_valid  = front_valid_in;
      rsp_word_in.shown_slot   = front_valid_in ? 4'(front_slot_in) : 4'd0;
      rsp_word_in.drop_total   = dropped_frames_in;
   end

   // Request register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   // Request payload.
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         req_word_ff <= req_word;
      end
   end

   // Response register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // Slot state, front slot and drop counter are committed as a word moves on.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SLOT_COUNT; k++) begin
            slot_states_ff[k] <= ST_FREE;
         end
         front_slot_ff     <= '0;
         front_valid_ff    <= 1'b0;
         dropped_frames_ff <= '0;
      end else if (advance) begin
         slot_states_ff    <= slot_states_in;
         front_slot_ff     <= front_slot_in;
         front_valid_ff    <= front_valid_in;
         dropped_frames_ff <= dropped_frames_in;
      end
   end

endmodule

### design/fbsm_checker.sv
// Port-level checks for the frame buffer slot manager, bound to the top level.
module fbsm_checker
   import fbsm_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   // A stalled response word stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response word dropped while stalled");

   // A grant always changes a slot and names a slot that exists.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.granted |->
         rsp_word.took_effect && (rsp_word.granted_slot < 4'(SLOT_COUNT)))
      else $error("grant without a valid slot change");

   // Without a grant the granted slot reads zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.granted |-> rsp_word.granted_slot == 4'd0)
      else $error("granted slot set without a grant");

   // The front slot reads zero when there is none, and exists when there is one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_word.shown_valid ? (rsp_word.shown_slot < 4'(SLOT_COUNT))
                               : (rsp_word.shown_slot == 4'd0)))
      else $error("front slot index inconsistent");

endmodule

bind frame_buffer_slot_manager_unit fbsm_checker u_fbsm_checker (.*);
